// ===== sv/bsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types and constants for the BMP stream decoder.
// ----------------------------------------------------------------------------
package bsd_pkg;

    localparam int DIM_W = 14;          // width / height storage, holds up to 16383

    localparam logic [31:0] MASK555_R = 32'h0000_7C00;
    localparam logic [31:0] MASK555_G = 32'h0000_03E0;
    localparam logic [31:0] MASK555_B = 32'h0000_001F;
    localparam logic [31:0] MASK888_R = 32'h00FF_0000;
    localparam logic [31:0] MASK888_G = 32'h0000_FF00;
    localparam logic [31:0] MASK888_B = 32'h0000_00FF;

    localparam logic [32:0] FILE_HDR_SIZE = 33'd14;
    localparam logic [31:0] CORE_HDR_SIZE = 32'd12;
    localparam logic [31:0] COMP_RGB      = 32'd0;
    localparam logic [31:0] COMP_BITFIELD = 32'd3;

    typedef enum logic [3:0] {
        KIND_WIDTH     = 4'd0,
        KIND_HEIGHT    = 4'd1,
        KIND_DEPTH     = 4'd2,
        KIND_MASK_R    = 4'd3,
        KIND_MASK_G    = 4'd4,
        KIND_MASK_B    = 4'd5,
        KIND_PALETTE   = 4'd6,
        KIND_PIXEL     = 4'd7,
        KIND_RAW       = 4'd8,
        KIND_ERR_FMT   = 4'd9,
        KIND_ERR_SIZE  = 4'd10
    } kind_t;

    typedef enum logic [2:0] {
        CMD_HDR,
        CMD_ERR_FMT,
        CMD_ERR_SIZE,
        CMD_PAL,
        CMD_PIX1,
        CMD_PIX4,
        CMD_RAW
    } cmd_t;

    // one queued command from the parser to the result generator
    typedef struct packed {
        cmd_t              cmd;
        logic [3:0]        num;      // results this command expands to
        logic [31:0]       value;
        logic [13:0]       column;
        logic [11:0]       row;
        logic              last;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [15:0]       depth;
        logic [31:0]       mask_r;
        logic [31:0]       mask_g;
        logic [31:0]       mask_b;
    } entry_t;

endpackage
`default_nettype wire

// ===== sv/bsd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsd_queue
// Two-entry command queue between parser and result generator.
// ----------------------------------------------------------------------------
module bsd_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire bsd_pkg::entry_t push_entry,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output bsd_pkg::entry_t      head
);
    import bsd_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// ===== sv/bsd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsd_front
// Byte parser: tracks file offset and header fields, classifies each byte
// and queues one command per byte that yields results.
// ----------------------------------------------------------------------------
module bsd_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_first,
    input  wire logic            q_full,
    output logic                 q_push,
    output bsd_pkg::entry_t      q_entry
);
    import bsd_pkg::*;

    logic [31:0]      off_reg, off_next;
    logic [31:0]      pdo_reg, pdo_next;
    logic [31:0]      hs_reg, hs_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic             width_big_reg, width_big_next;
    logic [DIM_W-1:0] height_reg, height_next;
    logic             height_big_reg, height_big_next;
    logic [15:0]      bpp_reg, bpp_next;
    logic [31:0]      comp_reg, comp_next;
    logic [31:0]      cu_reg, cu_next;
    logic [31:0]      mr_reg, mr_next;
    logic [31:0]      mg_reg, mg_next;
    logic [31:0]      mb_reg, mb_next;
    logic [15:0]      asm_reg, asm_next;
    logic [1:0]       pos_reg, pos_next;
    logic [8:0]       pidx_reg, pidx_next;
    logic [13:0]      rowc_reg, rowc_next;
    logic [15:0]      colc_reg, colc_next;
    logic             err_reg, err_next;
    logic             done_reg, done_next;

    logic             accept;
    logic [31:0]      o;
    logic [32:0]      o33;
    logic [1:0]       bsel;
    logic [3:0]       mrel;
    logic             core;
    logic [31:0]      hs40;
    logic [32:0]      p0;
    logic [32:0]      dstart;
    logic             depth_ok;
    logic             big_w, big_h;
    logic [1:0]       pos_last;
    logic [8:0]       pal_count;
    logic             pal_depth;
    logic [15:0]      data_bytes;
    logic [16:0]      padded;
    logic             last_row;
    logic [13:0]      row_img;
    logic [16:0]      xbase;
    logic [16:0]      remain;
    logic [16:0]      ppb;
    logic [16:0]      col_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    always_comb begin
        off_next        = off_reg;
        pdo_next        = pdo_reg;
        hs_next         = hs_reg;
        width_next      = width_reg;
        width_big_next  = width_big_reg;
        height_next     = height_reg;
        height_big_next = height_big_reg;
        bpp_next        = bpp_reg;
        comp_next       = comp_reg;
        cu_next         = cu_reg;
        mr_next         = mr_reg;
        mg_next         = mg_reg;
        mb_next         = mb_reg;
        asm_next        = asm_reg;
        pos_next        = pos_reg;
        pidx_next       = pidx_reg;
        rowc_next       = rowc_reg;
        colc_next       = colc_reg;
        err_next        = err_reg;
        done_next       = done_reg;
        q_push          = 1'b0;
        q_entry         = '0;

        // new file restarts everything
        if (in_first) begin
            pdo_next        = '0;
            hs_next         = '0;
            width_next      = '0;
            width_big_next  = 1'b0;
            height_next     = '0;
            height_big_next = 1'b0;
            bpp_next        = '0;
            comp_next       = '0;
            cu_next         = '0;
            mr_next         = '0;
            mg_next         = '0;
            mb_next         = '0;
            asm_next        = '0;
            pos_next        = '0;
            pidx_next       = '0;
            rowc_next       = '0;
            colc_next       = '0;
            err_next        = 1'b0;
            done_next       = 1'b0;
        end

        o    = in_first ? 32'd0 : off_reg;
        o33  = {1'b0, o};
        bsel = o[1:0] + 2'd2;            // byte lane within a 32-bit field
        mrel = 4'(o - 32'd54);
        core = 1'b0;
        hs40 = '0;
        p0   = '0;
        dstart    = '0;
        depth_ok  = 1'b0;
        big_w     = 1'b0;
        big_h     = 1'b0;
        pos_last  = '0;
        pal_count = '0;
        pal_depth = 1'b0;
        data_bytes = '0;
        padded    = '0;
        last_row  = 1'b0;
        row_img   = '0;
        xbase     = '0;
        remain    = '0;
        ppb       = '0;
        col_inc   = '0;

        if (accept) begin
            off_next = (o == 32'hFFFF_FFFF) ? o : o + 32'd1;
        end

        if (accept && !err_next && !done_next) begin
            core = (hs_next == CORE_HDR_SIZE);

            // header field capture
            unique case (o)
                32'd10, 32'd11, 32'd12, 32'd13: pdo_next[8*bsel +: 8] = in_byte;
                32'd14, 32'd15, 32'd16, 32'd17: hs_next[8*bsel +: 8] = in_byte;
                32'd18: width_next[7:0] = in_byte;
                32'd19: begin
                    width_next[13:8] = in_byte[5:0];
                    width_big_next   = width_big_next | (|in_byte[7:6]);
                end
                32'd20: begin
                    if (core) height_next[7:0] = in_byte;
                    else width_big_next = width_big_next | (|in_byte);
                end
                32'd21: begin
                    if (core) begin
                        height_next[13:8] = in_byte[5:0];
                        height_big_next   = height_big_next | (|in_byte[7:6]);
                    end else begin
                        width_big_next = width_big_next | (|in_byte);
                    end
                end
                32'd22: if (!core) height_next[7:0] = in_byte;
                32'd23: begin
                    if (!core) begin
                        height_next[13:8] = in_byte[5:0];
                        height_big_next   = height_big_next | (|in_byte[7:6]);
                    end
                end
                32'd24: begin
                    if (core) bpp_next[7:0] = in_byte;
                    else height_big_next = height_big_next | (|in_byte);
                end
                32'd25: begin
                    if (core) bpp_next[15:8] = in_byte;
                    else height_big_next = height_big_next | (|in_byte);
                end
                32'd28: if (!core) bpp_next[7:0] = in_byte;
                32'd29: if (!core) bpp_next[15:8] = in_byte;
                32'd30, 32'd31, 32'd32, 32'd33: begin
                    if (!core) comp_next[8*bsel +: 8] = in_byte;
                end
                32'd46, 32'd47, 32'd48, 32'd49: begin
                    if (!core) cu_next[8*bsel +: 8] = in_byte;
                end
                default: begin
                    // bitfield masks at 54..65
                    if (o >= 32'd54 && o <= 32'd65 && !core && comp_next == COMP_BITFIELD) begin
                        unique case (mrel[3:2])
                            2'd0:    mr_next[8*bsel +: 8] = in_byte;
                            2'd1:    mg_next[8*bsel +: 8] = in_byte;
                            default: mb_next[8*bsel +: 8] = in_byte;
                        endcase
                    end
                end
            endcase

            // palette start and pixel data start
            hs40 = (hs_next < 32'd40) ? 32'd40 : hs_next;
            if (core) begin
                p0 = 33'd26;
            end else begin
                p0 = FILE_HDR_SIZE + {1'b0, hs40};
                if (comp_next == COMP_BITFIELD && p0 < 33'd66) p0 = 33'd66;
            end
            dstart = ({1'b0, pdo_next} > p0) ? {1'b0, pdo_next} : p0;

            depth_ok = bpp_next == 16'd1 || bpp_next == 16'd4 || bpp_next == 16'd8 ||
                       bpp_next == 16'd15 || bpp_next == 16'd16 || bpp_next == 16'd24 ||
                       bpp_next == 16'd32;
            big_w = width_big_next  || ({1'b0, width_next}  > 15'(MAX_WIDTH));
            big_h = height_big_next || ({1'b0, height_next} > 15'(MAX_HEIGHT));

            pos_last  = core ? 2'd2 : 2'd3;
            pal_depth = bpp_next == 16'd1 || bpp_next == 16'd4 || bpp_next == 16'd8;
            if (cu_next == 32'd0) begin
                pal_count = (bpp_next == 16'd1) ? 9'd2 :
                            (bpp_next == 16'd4) ? 9'd16 : 9'd256;
            end else begin
                pal_count = (cu_next > 32'd256) ? 9'd256 : cu_next[8:0];
            end

            unique case (bpp_next)
                16'd1:   data_bytes = 16'(({2'b0, width_next} + 16'd7) >> 3);
                16'd4:   data_bytes = 16'(({2'b0, width_next} + 16'd1) >> 1);
                16'd8:   data_bytes = {2'b0, width_next};
                16'd24:  data_bytes = {2'b0, width_next} + {1'b0, width_next, 1'b0};
                16'd32:  data_bytes = {width_next, 2'b0};
                default: data_bytes = {1'b0, width_next, 1'b0};
            endcase
            padded   = ({1'b0, data_bytes} + 17'd3) & ~17'd3;
            last_row = ({1'b0, rowc_next} + 15'd1) == {1'b0, height_next};
            row_img  = height_next - 14'd1 - rowc_next;

            if (!(o < 32'd25 || (!core && o < 32'd53))) begin
                priority if (o33 + 33'd1 == p0) begin
                    if ((!core && comp_next != COMP_RGB && comp_next != COMP_BITFIELD) ||
                        !depth_ok) begin
                        err_next      = 1'b1;
                        q_push        = 1'b1;
                        q_entry.cmd   = CMD_ERR_FMT;
                        q_entry.num   = 4'd1;
                    end else if (big_w || big_h) begin
                        err_next      = 1'b1;
                        q_push        = 1'b1;
                        q_entry.cmd   = CMD_ERR_SIZE;
                        q_entry.num   = 4'd1;
                    end else begin
                        q_push         = 1'b1;
                        q_entry.cmd    = CMD_HDR;
                        q_entry.num    = 4'd6;
                        q_entry.width  = width_next;
                        q_entry.height = height_next;
                        q_entry.depth  = bpp_next;
                        if (!core && comp_next == COMP_BITFIELD) begin
                            if (bpp_next == 16'd15 || bpp_next == 16'd16 ||
                                bpp_next == 16'd32) begin
                                q_entry.mask_r = mr_next;
                                q_entry.mask_g = mg_next;
                                q_entry.mask_b = mb_next;
                            end
                        end else if (bpp_next == 16'd15 || bpp_next == 16'd16) begin
                            q_entry.mask_r = MASK555_R;
                            q_entry.mask_g = MASK555_G;
                            q_entry.mask_b = MASK555_B;
                        end else if (bpp_next == 16'd24 || bpp_next == 16'd32) begin
                            q_entry.mask_r = MASK888_R;
                            q_entry.mask_g = MASK888_G;
                            q_entry.mask_b = MASK888_B;
                        end
                        if (width_next == '0 || height_next == '0) done_next = 1'b1;
                        pos_next  = '0;
                        pidx_next = '0;
                    end
                end else if (o33 < p0) begin
                    // gap before palette
                end else if (o33 < dstart) begin
                    if (pal_depth && pidx_next < pal_count) begin
                        unique case (pos_next)
                            2'd0: asm_next[7:0]  = in_byte;
                            2'd1: asm_next[15:8] = in_byte;
                            2'd2: begin
                                q_push         = 1'b1;
                                q_entry.cmd    = CMD_PAL;
                                q_entry.num    = 4'd1;
                                q_entry.value  = {8'h00, in_byte, asm_next};
                                q_entry.column = {5'b0, pidx_next};
                            end
                            default: ;
                        endcase
                    end
                    if (pos_next == pos_last) begin
                        pos_next  = '0;
                        pidx_next = (pidx_next == 9'd256) ? pidx_next : pidx_next + 9'd1;
                    end else begin
                        pos_next = pos_next + 2'd1;
                    end
                end else begin
                    col_inc = {1'b0, colc_next} + 17'd1;
                    if ({1'b0, colc_next} < {1'b0, data_bytes}) begin
                        q_push      = 1'b1;
                        q_entry.row = row_img[11:0];
                        if (bpp_next == 16'd1 || bpp_next == 16'd4) begin
                            xbase  = (bpp_next == 16'd1) ? {colc_next[13:0], 3'b0}
                                                         : {colc_next, 1'b0};
                            ppb    = (bpp_next == 16'd1) ? 17'd8 : 17'd2;
                            remain = {3'b0, width_next} - xbase;
                            q_entry.cmd    = (bpp_next == 16'd1) ? CMD_PIX1 : CMD_PIX4;
                            q_entry.num    = (remain < ppb) ? remain[3:0] : ppb[3:0];
                            q_entry.value  = {24'h0, in_byte};
                            q_entry.column = xbase[13:0];
                            q_entry.last   = last_row && (remain <= ppb);
                        end else begin
                            q_entry.cmd    = CMD_RAW;
                            q_entry.num    = 4'd1;
                            q_entry.value  = {24'h0, in_byte};
                            q_entry.column = colc_next[13:0];
                            q_entry.last   = last_row && (col_inc == {1'b0, data_bytes});
                        end
                    end
                    if ({1'b0, colc_next} < {1'b0, data_bytes} && last_row &&
                        col_inc == {1'b0, data_bytes}) begin
                        done_next = 1'b1;
                    end else if (col_inc >= padded) begin
                        colc_next = '0;
                        rowc_next = rowc_next + 14'd1;
                        if (rowc_next >= height_next) done_next = 1'b1;
                    end else begin
                        colc_next = col_inc[15:0];
                    end
                end
            end
        end else if (accept) begin
            core = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg        <= '0;
            pdo_reg        <= '0;
            hs_reg         <= '0;
            width_reg      <= '0;
            width_big_reg  <= 1'b0;
            height_reg     <= '0;
            height_big_reg <= 1'b0;
            bpp_reg        <= '0;
            comp_reg       <= '0;
            cu_reg         <= '0;
            mr_reg         <= '0;
            mg_reg         <= '0;
            mb_reg         <= '0;
            asm_reg        <= '0;
            pos_reg        <= '0;
            pidx_reg       <= '0;
            rowc_reg       <= '0;
            colc_reg       <= '0;
            err_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end else if (accept) begin
            off_reg        <= off_next;
            pdo_reg        <= pdo_next;
            hs_reg         <= hs_next;
            width_reg      <= width_next;
            width_big_reg  <= width_big_next;
            height_reg     <= height_next;
            height_big_reg <= height_big_next;
            bpp_reg        <= bpp_next;
            comp_reg       <= comp_next;
            cu_reg         <= cu_next;
            mr_reg         <= mr_next;
            mg_reg         <= mg_next;
            mb_reg         <= mb_next;
            asm_reg        <= asm_next;
            pos_reg        <= pos_next;
            pidx_reg       <= pidx_next;
            rowc_reg       <= rowc_next;
            colc_reg       <= colc_next;
            err_reg        <= err_next;
            done_reg       <= done_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/bsd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsd_back
// Result generator: expands each queued command into one result per cycle,
// unless the output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module bsd_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire bsd_pkg::entry_t q_head,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [63:0]          m_tdata,
    output logic [3:0]           m_tuser,
    output logic                 m_tlast
);
    import bsd_pkg::*;

    logic [2:0]  k_reg, k_next;
    logic        mv_reg, mv_next;
    logic [63:0] md_reg, md_next;
    logic [3:0]  mk_reg, mk_next;
    logic        ml_reg, ml_next;

    logic        fire;
    logic        final_k;
    kind_t       r_kind;
    logic [31:0] r_value;
    logic [13:0] r_col;
    logic [11:0] r_row;
    logic        r_last;

    assign fire    = q_valid && (!mv_reg || m_tready);
    assign final_k = ({1'b0, k_reg} + 4'd1) == q_head.num;
    assign q_pop   = fire && final_k;

    always_comb begin
        r_kind  = KIND_ERR_FMT;
        r_value = '0;
        r_col   = '0;
        r_row   = '0;
        r_last  = 1'b0;
        unique case (q_head.cmd)
            CMD_HDR: begin
                r_kind = kind_t'({1'b0, k_reg});
                unique case (k_reg)
                    3'd0:    r_value = {18'h0, q_head.width};
                    3'd1:    r_value = {18'h0, q_head.height};
                    3'd2:    r_value = {16'h0, q_head.depth};
                    3'd3:    r_value = q_head.mask_r;
                    3'd4:    r_value = q_head.mask_g;
                    default: r_value = q_head.mask_b;
                endcase
            end
            CMD_ERR_FMT:  r_kind = KIND_ERR_FMT;
            CMD_ERR_SIZE: r_kind = KIND_ERR_SIZE;
            CMD_PAL: begin
                r_kind  = KIND_PALETTE;
                r_value = q_head.value;
                r_col   = q_head.column;
            end
            CMD_PIX1, CMD_PIX4: begin
                r_kind  = KIND_PIXEL;
                if (q_head.cmd == CMD_PIX1) begin
                    r_value = {31'h0, q_head.value[3'd7 - k_reg]};
                end else begin
                    r_value = (k_reg == 3'd0) ? {28'h0, q_head.value[7:4]}
                                              : {28'h0, q_head.value[3:0]};
                end
                r_col  = q_head.column + {11'h0, k_reg};
                r_row  = q_head.row;
                r_last = q_head.last && final_k;
            end
            default: begin
                r_kind  = KIND_RAW;
                r_value = q_head.value;
                r_col   = q_head.column;
                r_row   = q_head.row;
                r_last  = q_head.last;
            end
        endcase
    end

    always_comb begin
        k_next  = k_reg;
        mv_next = mv_reg;
        md_next = md_reg;
        mk_next = mk_reg;
        ml_next = ml_reg;
        if (fire) begin
            mv_next = 1'b1;
            md_next = {6'h0, r_row, r_col, r_value};
            mk_next = r_kind;
            ml_next = r_last;
            k_next  = final_k ? 3'd0 : k_reg + 3'd1;
        end else if (m_tready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg  <= '0;
            mv_reg <= 1'b0;
        end else begin
            k_reg  <= k_next;
            mv_reg <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        md_reg <= md_next;
        mk_reg <= mk_next;
        ml_reg <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mk_reg;
    assign m_tlast  = ml_reg;

endmodule
`default_nettype wire

// ===== sv/bmp_stream_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_stream_decoder
// Streaming BMP decoder: file bytes in, header/palette/pixel results out.
// ----------------------------------------------------------------------------
// The file arrives one byte per transaction on the slave side; tuser high
// marks byte 0 of a new file and restarts the parse. The parser takes a byte
// while the queue is not full and queues at most one command per byte in a
// two-entry queue. The result generator drains it at one result per cycle,
// unless the master side stalls, into a registered master stage; a 1-bit
// image byte yields up to eight results, a 4-bit byte up to two, a header-complete
// byte six, all others one (or none). The queue decouples both sides, so
// input bytes keep flowing while results are stalled, until the queue fills.
// Results: width, height, depth and R/G/B masks once the header is in,
// then palette entries, then pixel indices (1/4-bit) or raw row bytes.
// Unsupported format or an image beyond MAX_WIDTH/MAX_HEIGHT gives a
// single error result and the rest of the file is dropped.
// ----------------------------------------------------------------------------
module bmp_stream_decoder #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] first
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] value, [45:32] column, [57:46] row
    output logic [3:0]       m_tuser,   // [3:0] kind
    output logic             m_tlast
);
    import bsd_pkg::*;

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    entry_t q_entry;
    entry_t q_head;

    // parser: offset tracking, header capture, per-byte classification
    bsd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_first (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    // command queue between parser and result generator
    bsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    // result generator with registered output
    bsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // header and error results carry no position
    a_hdr_no_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_WIDTH || m_tuser == KIND_HEIGHT ||
                     m_tuser == KIND_DEPTH || m_tuser == KIND_ERR_FMT ||
                     m_tuser == KIND_ERR_SIZE) |-> m_tdata[57:32] == 26'h0)
        else $error("header/error result with nonzero position");

    // pixel indices are at most four bits
    a_pix_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_PIXEL |-> m_tdata[31:4] == 28'h0)
        else $error("pixel index too wide");

    // last only on pixel or raw transactions
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tuser == KIND_PIXEL || m_tuser == KIND_RAW))
        else $error("tlast on non-pixel result");

endmodule
`default_nettype wire

// ===== tb/bmp_stream_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_stream_decoder_tb
// Self-checking bench: streams BMP files byte by byte and checks every result.
// ----------------------------------------------------------------------------
// Files are built on the fly (core and info headers, all depths, bitfields,
// palettes, padding, error cases, truncated files and noise). A scoreboard
// predicts the result transactions for each accepted byte and compares them,
// in order, with what the block delivers. Both sides stall at random.
// ----------------------------------------------------------------------------
module bmp_stream_decoder_tb;
    import bsd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        kind_t       kind;
        logic [31:0] value;
        logic [13:0] column;
        logic [11:0] row;
        logic        last;
    } bmp_result_t;

    // scoreboard: own copy of the decoder state, queue of pending results
    class bmp_scoreboard;
        bmp_result_t pending_q[$];
        int          errors;
        int          matched;
        bit [31:0]   offs, pix_ofs, hdr_sz, wid, hgt, bpp, comp, ncol, pal_acc;
        bit [31:0]   masks[3];
        bit [31:0]   row_cnt, col_cnt;
        bit          failed, finished;

        function void clear_state();
            offs = 0; pix_ofs = 0; hdr_sz = 0; wid = 0; hgt = 0; bpp = 0;
            comp = 0; ncol = 0; pal_acc = 0; row_cnt = 0; col_cnt = 0;
            masks[0] = 0; masks[1] = 0; masks[2] = 0;
            failed = 0; finished = 0;
        endfunction

        function bit is_core();
            return hdr_sz == CORE_HDR_SIZE;
        endfunction

        function longint pal_start();
            longint hs;
            if (is_core()) return 26;
            hs = (hdr_sz < 40) ? 40 : hdr_sz;
            hs = hs + 14;
            if (comp == COMP_BITFIELD && hs < 66) hs = 66;
            return hs;
        endfunction

        function void push(kind_t k, bit [31:0] v, bit [31:0] c, bit [31:0] r, bit l);
            bmp_result_t e;
            e.kind = k; e.value = v; e.column = c[13:0]; e.row = r[11:0]; e.last = l;
            pending_q.push_back(e);
        endfunction

        function void header_done();
            bit [31:0] d;
            d = bpp;
            if (!is_core() && comp != COMP_RGB && comp != COMP_BITFIELD) begin
                failed = 1; push(KIND_ERR_FMT, 0, 0, 0, 0); return;
            end
            if (!(d == 1 || d == 4 || d == 8 || d == 15 || d == 16 || d == 24 || d == 32)) begin
                failed = 1; push(KIND_ERR_FMT, 0, 0, 0, 0); return;
            end
            if (wid > 4096 || hgt > 4096) begin
                failed = 1; push(KIND_ERR_SIZE, 0, 0, 0, 0); return;
            end
            if (!is_core() && comp == COMP_BITFIELD) begin
                if (d != 15 && d != 16 && d != 32) begin
                    masks[0] = 0; masks[1] = 0; masks[2] = 0;
                end
            end else if (d == 15 || d == 16) begin
                masks[0] = MASK555_R; masks[1] = MASK555_G; masks[2] = MASK555_B;
            end else if (d == 24 || d == 32) begin
                masks[0] = MASK888_R; masks[1] = MASK888_G; masks[2] = MASK888_B;
            end else begin
                masks[0] = 0; masks[1] = 0; masks[2] = 0;
            end
            push(KIND_WIDTH, wid, 0, 0, 0);
            push(KIND_HEIGHT, hgt, 0, 0, 0);
            push(KIND_DEPTH, d, 0, 0, 0);
            push(KIND_MASK_R, masks[0], 0, 0, 0);
            push(KIND_MASK_G, masks[1], 0, 0, 0);
            push(KIND_MASK_B, masks[2], 0, 0, 0);
            if (wid == 0 || hgt == 0) finished = 1;
        endfunction

        function void palette_byte(longint o, longint p0, bit [31:0] b);
            longint esz, rel, idx, pos, count;
            esz = is_core() ? 3 : 4;
            rel = o - p0; idx = rel / esz; pos = rel % esz;
            if (bpp != 1 && bpp != 4 && bpp != 8) return;
            count = (ncol != 0) ? longint'(ncol) : (longint'(1) << bpp);
            if (count > 256) count = 256;
            if (idx >= count) return;
            if (pos == 0) pal_acc = b;
            else if (pos == 1) pal_acc = (pal_acc & 32'hFF) | (b << 8);
            else if (pos == 2) begin
                pal_acc = (pal_acc & 32'hFFFF) | (b << 16);
                push(KIND_PALETTE, pal_acc & 32'hFF_FFFF, idx[31:0], 0, 0);
            end
        endfunction

        function void pixel_byte(bit [31:0] b);
            bit [31:0] data, padded, col, r, x, ppb, v;
            bit        last_row;
            case (bpp)
                1:  data = (wid + 7) >> 3;
                4:  data = (wid + 1) >> 1;
                8:  data = wid;
                24: data = wid * 3;
                32: data = wid * 4;
                default: data = wid * 2;
            endcase
            padded = (data + 3) & ~32'd3;
            col = col_cnt;
            r = hgt - 1 - row_cnt;
            last_row = (row_cnt + 1 == hgt);
            if (col < data) begin
                if (bpp == 1 || bpp == 4) begin
                    ppb = 8 / bpp;
                    for (int k = 0; k < ppb; k++) begin
                        x = col * ppb + k;
                        if (x < wid) begin
                            v = (b >> (8 - bpp * (k + 1))) & ((32'd1 << bpp) - 1);
                            push(KIND_PIXEL, v, x, r, last_row && (x + 1 == wid));
                        end
                    end
                end else begin
                    push(KIND_RAW, b, col, r, last_row && (col + 1 == data));
                end
                if (last_row && col + 1 == data) begin
                    finished = 1; return;
                end
            end
            col++;
            if (col >= padded) begin
                col = 0;
                row_cnt++;
                if (row_cnt >= hgt) finished = 1;
            end
            col_cnt = col;
        endfunction

        // accepted input byte: update state, queue expected results
        function void note_byte(bit [7:0] db, bit first_flag);
            longint o, p0, ds, pd;
            bit [31:0] b;
            b = db;
            if (first_flag) clear_state();
            o = offs;
            if (offs != 32'hFFFF_FFFF) offs++;
            if (failed || finished) return;
            if (o >= 10 && o <= 13) pix_ofs |= b << (8 * (o - 10));
            else if (o >= 14 && o <= 17) hdr_sz |= b << (8 * (o - 14));
            else if (is_core()) begin
                if (o == 18 || o == 19) wid |= b << (8 * (o - 18));
                else if (o == 20 || o == 21) hgt |= b << (8 * (o - 20));
                else if (o == 24 || o == 25) bpp |= b << (8 * (o - 24));
            end else begin
                if (o >= 18 && o <= 21) wid |= b << (8 * (o - 18));
                else if (o >= 22 && o <= 25) hgt |= b << (8 * (o - 22));
                else if (o == 28 || o == 29) bpp |= b << (8 * (o - 28));
                else if (o >= 30 && o <= 33) comp |= b << (8 * (o - 30));
                else if (o >= 46 && o <= 49) ncol |= b << (8 * (o - 46));
                else if (o >= 54 && o <= 65 && comp == COMP_BITFIELD)
                    masks[(o - 54) >> 2] |= b << (8 * ((o - 54) & 3));
            end
            if (o < 25 || (!is_core() && o < 53)) return;
            p0 = pal_start();
            if (o + 1 == p0) begin
                header_done();
                return;
            end
            if (o < p0) return;
            pd = pix_ofs;
            ds = (pd > p0) ? pd : p0;
            if (o < ds) palette_byte(o, p0, b);
            else pixel_byte(b);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(bmp_result_t got);
            bmp_result_t w;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected result kind %0d value %h",
                                 got.kind, got.value));
                return;
            end
            w = pending_q.pop_front();
            matched++;
            if (got.kind !== w.kind)
                report($sformatf("kind %0d, want %0d", got.kind, w.kind));
            if (got.value !== w.value)
                report($sformatf("value %h, want %h (kind %0d)", got.value, w.value, w.kind));
            if (got.column !== w.column)
                report($sformatf("column %0d, want %0d", got.column, w.column));
            if (got.row !== w.row)
                report($sformatf("row %0d, want %0d", got.row, w.row));
            if (got.last !== w.last)
                report($sformatf("last %0b, want %0b", got.last, w.last));
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    bmp_scoreboard sb = new();
    bit [7:0] file_q[$];     // bytes of the file being built
    bit   tx_burst, rx_burst;  // no-gap modes per side
    bit   long_hold_req;
    int   cycles, bytes_sent, files_sent;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    bmp_stream_decoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("bmp_stream_decoder_tb: errors");
            $finish;
        end
    end

    // result monitor: accepted transaction = tvalid & tready at the edge
    always @(posedge aclk) begin
        bmp_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = kind_t'(m_tuser);
            got.value = m_tdata[31:0];
            got.column = m_tdata[45:32];
            got.row = m_tdata[57:46];
            got.last = m_tlast;
            sb.check_result(got);
        end
    end

    // receiver: random stall per result, plus one long hold-off on request
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_tready <= 0;
                repeat (400) @(negedge aclk);
                long_hold_req = 0;
            end
            stall = rx_burst ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_tready <= 0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // one byte transaction; entered and left at a falling edge
    task send_byte(bit [7:0] b, bit f);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= b;
        s_tuser <= f;
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(b, f);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task put_le(int ofs, bit [31:0] v, int n);
        for (int i = 0; i < n; i++) file_q[ofs + i] = v[8*i +: 8];
    endtask

    // build a file into file_q; pix_adj moves the pixel data offset
    // relative to the end of the palette (negative overlaps the palette)
    task build_file(bit core, int hs, bit [31:0] w, bit [31:0] h, int d, bit [31:0] cmp,
                    int cu, int pix_adj, bit valid_img);
        int pstart, cnt, pal_bytes, data, padded, npix;
        file_q.delete();
        if (core) pstart = 26;
        else begin
            pstart = 14 + ((hs < 40) ? 40 : hs);
            if (cmp == COMP_BITFIELD && pstart < 66) pstart = 66;
        end
        for (int i = 0; i < pstart; i++) file_q.push_back($urandom_range(0, 255));
        file_q[0] = 8'h42; file_q[1] = 8'h4D;
        put_le(14, core ? CORE_HDR_SIZE : hs, 4);
        if (core) begin
            put_le(18, w, 2); put_le(20, h, 2); put_le(24, d, 2);
        end else begin
            put_le(18, w, 4); put_le(22, h, 4); put_le(28, d, 2);
            put_le(30, cmp, 4); put_le(46, cu, 4);
        end
        cnt = 0;
        if (d == 1 || d == 4 || d == 8) begin
            cnt = (cu != 0) ? cu : (1 << d);
            if (cnt > 256) cnt = 256;
        end
        pal_bytes = cnt * (core ? 3 : 4);
        put_le(10, pstart + pal_bytes + pix_adj, 4);
        case (d)
            1:  data = (w + 7) / 8;
            4:  data = (w + 1) / 2;
            8:  data = w;
            24: data = w * 3;
            32: data = w * 4;
            default: data = w * 2;
        endcase
        padded = (data + 3) & ~3;
        npix = valid_img ? padded * h : 12;
        if (pix_adj > 0) npix += pix_adj;
        for (int i = 0; i < pal_bytes + npix; i++) file_q.push_back($urandom_range(0, 255));
    endtask

    // stream file_q; optionally cut short, optionally followed by stray bytes
    task send_file(int cut, int extra);
        int n;
        n = (cut > 0 && cut < file_q.size()) ? cut : file_q.size();
        for (int i = 0; i < n; i++) send_byte(file_q[i], i == 0);
        for (int i = 0; i < extra; i++) send_byte($urandom_range(0, 255), 0);
        files_sent++;
    endtask

    task directed(bit core, int hs, bit [31:0] w, bit [31:0] h, int d, bit [31:0] cmp,
                  int cu, int pix_adj, bit valid_img);
        build_file(core, hs, w, h, d, cmp, cu, pix_adj, valid_img);
        send_file(0, 2);
    endtask

    task random_file();
        int sel, d, cu, cmp, hs;
        int depths[7] = '{1, 4, 8, 15, 16, 24, 32};
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            // noise: random bytes with a first flag
            file_q.delete();
            repeat ($urandom_range(10, 40)) file_q.push_back($urandom_range(0, 255));
            send_file(0, 0);
            return;
        end
        d = depths[$urandom_range(0, 6)];
        cmp = ($urandom_range(0, 2) == 0) ? COMP_BITFIELD : COMP_RGB;
        cu = (d == 8) ? $urandom_range(1, 6) : (($urandom_range(0, 1) == 1) ? 0 : (1 << d) / 2);
        hs = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 60) : 40;
        if (sel == 1) cmp = $urandom_range(4, 255);
        if (sel == 2) d = 9;
        build_file($urandom_range(0, 4) == 0, hs, $urandom_range(1, 10), $urandom_range(1, 3),
                   d, cmp, cu, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 0,
                   sel > 2);
        if (sel == 3) send_file($urandom_range(5, 70), 0);   // truncated file
        else send_file(0, $urandom_range(0, 3));
    endtask

    // sender idles until every predicted result has come out
    task wait_drained();
        s_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed files
        directed(1, 12, 9, 2, 1, 0, 0, 0, 1);                  // core 1-bit, palette of 2
        directed(0, 40, 6, 1, 8, COMP_RGB, 2, -4, 1);          // pixel data overlaps palette
        directed(0, 20, 3, 1, 16, COMP_BITFIELD, 0, 0, 1);     // short header, file masks
        directed(1, 12, 2, 2, 7, 0, 0, 0, 0);                  // unsupported depth
        directed(1, 12, 4097, 1, 8, 0, 2, 0, 0);               // core, too wide
        directed(1, 12, 0, 3, 8, 0, 2, 0, 0);                  // zero width

        // sender pause until the block has delivered everything
        wait_drained();

        // one long receiver hold-off while bytes keep coming
        long_hold_req = 1;
        tx_burst = 1;
        build_file(1, 12, 16, 3, 1, 0, 0, 0, 1);
        send_file(0, 0);

        // random files
        while (bytes_sent < 380) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            random_file();
        end

        rx_burst = 0;
        wait_drained();
        repeat (40) @(posedge aclk);

        $display("covered %0d files, %0d bytes, %0d results checked", files_sent,
                 bytes_sent, sb.matched);
        $display("core/info/bitfield headers, palettes, error cases, random files, stalls");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("bmp_stream_decoder_tb: clean");
        end else begin
            $display("bmp_stream_decoder_tb: errors");
        end
        $finish;
    end

endmodule
